// ===== rtl/core/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

   localparam int MAX_ENTRIES_DEF = 64;
   localparam int ADDR_BITS_DEF   = 20;
   localparam int OWNER_BITS_DEF  = 8;

   localparam int CFG_BITS     = 21;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [CFG_BITS-1:0] TOTAL_RESET   = CFG_BITS'(16384);
   localparam logic [CFG_BITS-1:0] REQUEST_RESET = CFG_BITS'(4096);

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOTAL_MEMORY = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REQUEST_SIZE = 2'd1;

   // opcodes; any other code acts as a query
   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_CLEAR,
      ST_IDLE,
      ST_A_CHK,
      ST_SH_RD,
      ST_SH_WR,
      ST_SPLIT_REM,
      ST_SPLIT_GNT,
      ST_R_CHK,
      ST_R_END,
      ST_UPD,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic idle;
      logic init;
      logic clear;
      logic a_next;
      logic a_exact;
      logic a_split;
      logic a_full;
      logic sh_rd;
      logic sh_wr;
      logic split_rem;
      logic split_gnt;
      logic r_step;
      logic r_end;
      logic upd;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic       req_fire;
      logic [1:0] req_op;
      logic       cfg_total_wr;
      logic       clr_done;
      logic       at_end;
      logic       fit;
      logic       exact;
      logic       full_cond;
      logic       sh_done;
      logic       rsp_free;
   } status_type;

endpackage

// ===== rtl/core/ffa_if.sv =====
// ----------------------------------------------------------------------------
// ffa_if
// Channel interfaces: request, response and register write.
// ----------------------------------------------------------------------------
interface ffa_req_if #(parameter int OWNER_BITS = 8);
   logic                  valid;
   logic                  ready;
   logic [1:0]            opcode;
   logic [OWNER_BITS-1:0] owner_id;

   modport source (output valid, opcode, owner_id, input ready);
   modport sink   (input valid, opcode, owner_id, output ready);
endinterface

interface ffa_rsp_if #(parameter int ADDR_BITS = 20, parameter int COUNT_BITS = 7);
   logic                  valid;
   logic                  ready;
   logic                  success;
   logic [ADDR_BITS-1:0]  start_address;
   logic                  table_full;
   logic                  owner_present;
   logic [ADDR_BITS:0]    used_memory;
   logic [ADDR_BITS:0]    free_memory;
   logic [COUNT_BITS-1:0] owner_count;

   modport source (output valid, success, start_address, table_full, owner_present,
                   used_memory, free_memory, owner_count, input ready);
   modport sink   (input valid, success, start_address, table_full, owner_present,
                   used_memory, free_memory, owner_count, output ready);
endinterface

interface ffa_csr_if #(parameter int IDX_BITS = 2, parameter int DATA_BITS = 21);
   logic                 valid;
   logic                 ready;
   logic [IDX_BITS-1:0]  wr_index;
   logic [DATA_BITS-1:0] wr_data;

   modport source (output valid, wr_index, wr_data, input ready);
   modport sink   (input valid, wr_index, wr_data, output ready);
endinterface

// ===== rtl/core/first_fit_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit allocator over an address-ordered block table, with merge on
// release.
// ----------------------------------------------------------------------------
// Usage:
//  req_bus carries one beat per operation: opcode (allocate, release all
//  blocks of owner, query) and owner_id. rsp_bus returns one beat per
//  request with grant, start address, table-full flag, owner presence,
//  used/free totals and the number of distinct owners.
//  csr_bus writes total_memory (index 0, rebuilds the table) and
//  request_size (index 1); it is always ready.
//  Allocate scans one entry per cycle up to the first free entry that fits:
//  an exact fit is granted in place; a split shifts the tail entries up by
//  one, then writes the remainder and the grant. Release is one
//  read-merge-write pass. The table RAM reads one entry and writes one per
//  cycle. Reset and a total_memory write rebuild the table and clear the
//  per-owner count RAM, one owner per cycle, with req ready low meanwhile.
//  The response register holds while rsp ready is low; the next request is
//  taken meanwhile and waits in its final step until the register frees.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_core #(
   parameter int MAX_ENTRIES = ffa_pkg::MAX_ENTRIES_DEF,
   parameter int ADDR_BITS   = ffa_pkg::ADDR_BITS_DEF,
   parameter int OWNER_BITS  = ffa_pkg::OWNER_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ffa_req_if.sink   req_bus,
   ffa_rsp_if.source rsp_bus,
   ffa_csr_if.sink   csr_bus
);
   import ffa_pkg::*;

   cmd_type    cmd;
   status_type status;

   ffa_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   ffa_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .ADDR_BITS   (ADDR_BITS),
      .OWNER_BITS  (OWNER_BITS)
   ) u_dpath (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus),
      .cmd     (cmd),
      .status  (status)
   );
endmodule

// ===== rtl/core/ffa_ram.sv =====
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module ffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/ffa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer: table init, owner count sweep, allocate scan/shift/split,
// release-and-merge pass, totals update and response hand-off.
// ----------------------------------------------------------------------------
module ffa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  ffa_pkg::status_type status,
   output ffa_pkg::cmd_type    cmd
);
   import ffa_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT:  state_in = ST_CLEAR;
         ST_CLEAR: if (status.clr_done) state_in = ST_IDLE;
         ST_IDLE: begin
            if (status.req_fire) begin
               if (status.req_op == OP_ALLOC)        state_in = ST_A_CHK;
               else if (status.req_op == OP_RELEASE) state_in = ST_R_CHK;
               else                                  state_in = ST_UPD;
            end
         end
         ST_A_CHK: begin
            if (status.at_end)                       state_in = ST_UPD;
            else if (status.fit && status.exact)     state_in = ST_UPD;
            else if (status.fit && status.full_cond) state_in = ST_UPD;
            else if (status.fit)                     state_in = ST_SH_RD;
         end
         ST_SH_RD:     state_in = status.sh_done ? ST_SPLIT_REM : ST_SH_WR;
         ST_SH_WR:     state_in = ST_SH_RD;
         ST_SPLIT_REM: state_in = ST_SPLIT_GNT;
         ST_SPLIT_GNT: state_in = ST_UPD;
         ST_R_CHK:     if (status.at_end) state_in = ST_R_END;
         ST_R_END:     state_in = ST_UPD;
         ST_UPD:       state_in = ST_FIN;
         ST_FIN:       if (status.rsp_free) state_in = ST_IDLE;
         default:      state_in = ST_INIT;
      endcase
      // a total memory write rebuilds the table
      if (status.cfg_total_wr) state_in = ST_INIT;
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_INIT:  cmd.init  = 1'b1;
         ST_CLEAR: cmd.clear = 1'b1;
         ST_IDLE:  cmd.idle  = 1'b1;
         ST_A_CHK: begin
            if (!status.at_end) begin
               if (!status.fit)           cmd.a_next  = 1'b1;
               else if (status.exact)     cmd.a_exact = 1'b1;
               else if (status.full_cond) cmd.a_full  = 1'b1;
               else                       cmd.a_split = 1'b1;
            end
         end
         ST_SH_RD:     cmd.sh_rd     = !status.sh_done;
         ST_SH_WR:     cmd.sh_wr     = 1'b1;
         ST_SPLIT_REM: cmd.split_rem = 1'b1;
         ST_SPLIT_GNT: cmd.split_gnt = 1'b1;
         ST_R_CHK:     cmd.r_step    = !status.at_end;
         ST_R_END:     cmd.r_end     = 1'b1;
         ST_UPD:       cmd.upd       = 1'b1;
         ST_FIN:       cmd.load_rsp  = status.rsp_free;
         default:      cmd = '0;
      endcase
   end
endmodule

// ===== rtl/core/ffa_dpath.sv =====
// ----------------------------------------------------------------------------
// ffa_dpath
// Datapath: block table RAM, per-owner block count RAM, scan pointers,
// merge record, running totals, register file and response register.
// ----------------------------------------------------------------------------
module ffa_dpath #(
   parameter int MAX_ENTRIES = 64,
   parameter int ADDR_BITS   = 20,
   parameter int OWNER_BITS  = 8
) (
   input  logic                clock,
   input  logic                reset,
   ffa_req_if.sink             req_bus,
   ffa_rsp_if.source           rsp_bus,
   ffa_csr_if.sink             csr_bus,
   input  ffa_pkg::cmd_type    cmd,
   output ffa_pkg::status_type status
);
   import ffa_pkg::*;

   localparam int IW    = $clog2(MAX_ENTRIES);
   localparam int CW    = $clog2(MAX_ENTRIES + 1);
   localparam int SW    = ADDR_BITS + 1;
   localparam int EW    = ADDR_BITS + SW + OWNER_BITS + 1;
   localparam int WIDE  = ((SW > CFG_BITS) ? SW : CFG_BITS) + 1;
   localparam int ODEP  = 1 << OWNER_BITS;

   // entry word: {start, size, owner, taken}
   localparam int T_LSB = 0;
   localparam int O_LSB = 1;
   localparam int Z_LSB = O_LSB + OWNER_BITS;
   localparam int S_LSB = Z_LSB + SW;

   // registers and config
   logic [CFG_BITS-1:0]   total_ff, req_size_ff;
   logic [CW-1:0]         count_ff, idx_ff, k_ff;
   logic [IW-1:0]         w_ff;
   logic [1:0]            op_ff;
   logic [OWNER_BITS-1:0] owner_ff;
   logic [ADDR_BITS-1:0]  cur_start_ff;
   logic [SW-1:0]         cur_size_ff;
   logic [ADDR_BITS-1:0]  p_start_ff;
   logic [SW-1:0]         p_size_ff;
   logic [OWNER_BITS-1:0] p_owner_ff;
   logic                  p_taken_ff, pv_ff;
   logic [SW-1:0]         freed_ff, used_ff;
   logic                  cnt_cap_ff;
   logic [CW-1:0]         ocnt_ff, owners_ff;
   logic                  grant_ff, full_ff;
   logic [ADDR_BITS-1:0]  addr_ff;
   logic [OWNER_BITS-1:0] clr_ff;

   logic                  rsp_valid_ff, rsp_success_ff, rsp_full_ff, rsp_present_ff;
   logic [ADDR_BITS-1:0]  rsp_addr_ff;
   logic [SW-1:0]         rsp_used_ff, rsp_free_ff;
   logic [CW-1:0]         rsp_owners_ff;

   // RAM ports
   logic                  t_wr_en;
   logic [IW-1:0]         t_wr_addr, t_rd_addr;
   logic [EW-1:0]         t_wr_data, t_rd_data;
   logic                  c_wr_en;
   logic [OWNER_BITS-1:0] c_wr_addr;
   logic [CW-1:0]         c_wr_data, c_rd_data;

   logic                  req_fire, csr_fire;
   logic [ADDR_BITS-1:0]  e_start;
   logic [SW-1:0]         e_size;
   logic [OWNER_BITS-1:0] e_owner;
   logic                  e_taken, rel_hit, t_after, merge;
   logic [WIDE-1:0]       tot_w, lim_w, req_w, size_w;
   logic [SW-1:0]         limit;
   logic [CW-1:0]         idx_inc;
   logic                  is_alloc, is_release;

   assign req_fire = req_bus.valid && cmd.idle;
   assign csr_fire = csr_bus.valid;
   assign req_bus.ready = cmd.idle;
   assign csr_bus.ready = 1'b1;

   assign e_start = t_rd_data[S_LSB +: ADDR_BITS];
   assign e_size  = t_rd_data[Z_LSB +: SW];
   assign e_owner = t_rd_data[O_LSB +: OWNER_BITS];
   assign e_taken = t_rd_data[T_LSB];

   assign tot_w  = WIDE'(total_ff);
   assign lim_w  = WIDE'(1) << ADDR_BITS;
   assign limit  = SW'((tot_w > lim_w) ? lim_w : tot_w);
   assign req_w  = WIDE'(req_size_ff);
   assign size_w = WIDE'(e_size);
   assign idx_inc = idx_ff + CW'(1);

   assign rel_hit = e_taken && (e_owner == owner_ff);
   assign t_after = e_taken && !rel_hit;
   assign merge   = pv_ff && !p_taken_ff && !t_after;

   assign is_alloc   = (op_ff == OP_ALLOC);
   assign is_release = (op_ff == OP_RELEASE);

   always_comb begin
      status              = '0;
      status.req_fire     = req_fire;
      status.req_op       = req_bus.opcode;
      status.cfg_total_wr = csr_fire && (csr_bus.wr_index == CSR_TOTAL_MEMORY);
      status.clr_done     = &clr_ff;
      status.at_end       = (idx_ff >= count_ff);
      status.fit          = !e_taken && (req_size_ff != '0) && (size_w >= req_w);
      status.exact        = (size_w == req_w);
      status.full_cond    = (count_ff >= CW'(MAX_ENTRIES));
      status.sh_done      = (k_ff <= idx_inc);
      status.rsp_free     = !rsp_valid_ff || rsp_bus.ready;
   end

   // table RAM access
   always_comb begin
      t_wr_en   = 1'b0;
      t_wr_addr = idx_ff[IW-1:0];
      t_wr_data = t_rd_data;
      t_rd_addr = '0;
      if (cmd.a_next || cmd.r_step) t_rd_addr = idx_inc[IW-1:0];
      if (cmd.sh_rd) t_rd_addr = IW'(k_ff - CW'(1));
      if (cmd.init) begin
         t_wr_en   = 1'b1;
         t_wr_addr = '0;
         t_wr_data = {ADDR_BITS'(0), limit, OWNER_BITS'(0), 1'b0};
      end
      if (cmd.a_exact) begin
         t_wr_en   = 1'b1;
         t_wr_data = {e_start, e_size, owner_ff, 1'b1};
      end
      if (cmd.sh_wr) begin
         t_wr_en   = 1'b1;
         t_wr_addr = k_ff[IW-1:0];
      end
      if (cmd.split_rem) begin
         t_wr_en   = 1'b1;
         t_wr_addr = idx_inc[IW-1:0];
         t_wr_data = {cur_start_ff + ADDR_BITS'(req_size_ff),
                      cur_size_ff - SW'(req_size_ff), OWNER_BITS'(0), 1'b0};
      end
      if (cmd.split_gnt) begin
         t_wr_en   = 1'b1;
         t_wr_data = {cur_start_ff, SW'(req_size_ff), owner_ff, 1'b1};
      end
      if ((cmd.r_step && pv_ff && !merge) || cmd.r_end) begin
         t_wr_en   = 1'b1;
         t_wr_addr = w_ff;
         t_wr_data = {p_start_ff, p_size_ff, p_owner_ff, p_taken_ff};
      end
   end

   // owner count RAM access
   always_comb begin
      c_wr_en   = 1'b0;
      c_wr_addr = owner_ff;
      c_wr_data = '0;
      if (cmd.clear) begin
         c_wr_en   = 1'b1;
         c_wr_addr = clr_ff;
      end
      if (cmd.upd && is_alloc && grant_ff) begin
         c_wr_en   = 1'b1;
         c_wr_data = ocnt_ff + CW'(1);
      end
      if (cmd.upd && is_release) begin
         c_wr_en = 1'b1;
      end
   end

   ffa_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_table (
      .clock   (clock),
      .wr_en   (t_wr_en),
      .wr_addr (t_wr_addr),
      .wr_data (t_wr_data),
      .rd_addr (t_rd_addr),
      .rd_data (t_rd_data)
   );

   ffa_ram #(.WIDTH(CW), .DEPTH(ODEP)) u_owner_cnt (
      .clock   (clock),
      .wr_en   (c_wr_en),
      .wr_addr (c_wr_addr),
      .wr_data (c_wr_data),
      .rd_addr (req_bus.owner_id),
      .rd_data (c_rd_data)
   );

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= TOTAL_RESET;
         req_size_ff <= REQUEST_RESET;
      end else if (csr_fire) begin
         if (csr_bus.wr_index == CSR_TOTAL_MEMORY) total_ff <= csr_bus.wr_data;
         if (csr_bus.wr_index == CSR_REQUEST_SIZE) req_size_ff <= csr_bus.wr_data;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CW'(1);
         used_ff      <= '0;
         owners_ff    <= '0;
         clr_ff       <= '0;
         cnt_cap_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pv_ff        <= 1'b0;
      end else begin
         cnt_cap_ff <= req_fire;
         if (cmd.init) begin
            count_ff  <= CW'(1);
            used_ff   <= '0;
            owners_ff <= '0;
            clr_ff    <= '0;
         end
         if (cmd.clear) clr_ff <= clr_ff + OWNER_BITS'(1);
         if (req_fire) pv_ff <= 1'b0;
         if (cmd.r_step) pv_ff <= 1'b1;
         if (cmd.split_gnt) count_ff <= count_ff + CW'(1);
         if (cmd.r_end) count_ff <= CW'(w_ff) + CW'(1);
         if (cmd.upd && is_alloc && grant_ff) begin
            used_ff <= used_ff + SW'(req_size_ff);
            if (ocnt_ff == '0) owners_ff <= owners_ff + CW'(1);
         end
         if (cmd.upd && is_release) begin
            used_ff <= used_ff - freed_ff;
            if (ocnt_ff != '0) owners_ff <= owners_ff - CW'(1);
         end
         if (cmd.load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_bus.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cnt_cap_ff) ocnt_ff <= c_rd_data;
      if (req_fire) begin
         op_ff    <= req_bus.opcode;
         owner_ff <= req_bus.owner_id;
         idx_ff   <= '0;
         w_ff     <= '0;
         freed_ff <= '0;
         grant_ff <= 1'b0;
         full_ff  <= 1'b0;
         addr_ff  <= '0;
      end
      if (cmd.a_next) idx_ff <= idx_inc;
      if (cmd.a_exact) begin
         grant_ff <= 1'b1;
         addr_ff  <= e_start;
      end
      if (cmd.a_full) full_ff <= 1'b1;
      if (cmd.a_split) begin
         grant_ff     <= 1'b1;
         addr_ff      <= e_start;
         cur_start_ff <= e_start;
         cur_size_ff  <= e_size;
         k_ff         <= count_ff;
      end
      if (cmd.sh_wr) k_ff <= k_ff - CW'(1);
      if (cmd.r_step) begin
         idx_ff <= idx_inc;
         if (rel_hit) freed_ff <= freed_ff + e_size;
         if (merge) begin
            p_size_ff <= p_size_ff + e_size;
         end else begin
            if (pv_ff) w_ff <= w_ff + IW'(1);
            p_start_ff <= e_start;
            p_size_ff  <= e_size;
            p_owner_ff <= e_owner;
            p_taken_ff <= t_after;
         end
      end
      if (cmd.load_rsp) begin
         rsp_success_ff <= is_alloc ? grant_ff : 1'b1;
         rsp_addr_ff    <= (is_alloc && grant_ff) ? addr_ff : '0;
         rsp_full_ff    <= is_alloc && full_ff;
         rsp_present_ff <= is_release ? 1'b0
                         : ((is_alloc && grant_ff) || (ocnt_ff != '0));
         rsp_used_ff    <= used_ff;
         rsp_free_ff    <= limit - used_ff;
         rsp_owners_ff  <= owners_ff;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.success       = rsp_success_ff;
   assign rsp_bus.start_address = rsp_addr_ff;
   assign rsp_bus.table_full    = rsp_full_ff;
   assign rsp_bus.owner_present = rsp_present_ff;
   assign rsp_bus.used_memory   = rsp_used_ff;
   assign rsp_bus.free_memory   = rsp_free_ff;
   assign rsp_bus.owner_count   = rsp_owners_ff;
endmodule

// ===== rtl/core/ffa_checker.sv =====
// ----------------------------------------------------------------------------
// ffa_checker
// Port-level checks of the allocator's response channel.
// ----------------------------------------------------------------------------
module ffa_checker #(
   parameter int ADDR_BITS  = 20,
   parameter int COUNT_BITS = 7
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  success,
   input logic [ADDR_BITS-1:0]  start_address,
   input logic                  table_full,
   input logic                  owner_present,
   input logic [ADDR_BITS:0]    used_memory,
   input logic [ADDR_BITS:0]    free_memory,
   input logic [COUNT_BITS-1:0] owner_count
);
   logic [ADDR_BITS+1:0] mem_sum;
   assign mem_sum = {1'b0, used_memory} + {1'b0, free_memory};

   // a pending beat holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(used_memory) && $stable(success))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_fail_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (!success || table_full) |-> start_address == '0 && !success)
      else $error("failed grant carries an address or success");

   a_owner_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && owner_present |-> owner_count != '0 && used_memory != '0)
      else $error("present owner not counted");

   a_mem_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> mem_sum <= ((ADDR_BITS+2)'(1) << ADDR_BITS))
      else $error("used plus free exceeds address space");
endmodule

bind first_fit_block_allocator_core ffa_checker #(
   .ADDR_BITS  (ADDR_BITS),
   .COUNT_BITS ($clog2(MAX_ENTRIES + 1))
) u_ffa_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .success       (rsp_bus.success),
   .start_address (rsp_bus.start_address),
   .table_full    (rsp_bus.table_full),
   .owner_present (rsp_bus.owner_present),
   .used_memory   (rsp_bus.used_memory),
   .free_memory   (rsp_bus.free_memory),
   .owner_count   (rsp_bus.owner_count)
);
